// ===== hdl/fpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared opcodes and default sizes for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRACTION_BITS_DEF = 8;
    localparam int WORD_BITS_DEF     = 32;
    localparam int FUNC_BITS         = 4;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_ADD      = 4'd0,
        FN_SUB      = 4'd1,
        FN_MUL      = 4'd2,
        FN_DIV      = 4'd3,
        FN_GT       = 4'd4,
        FN_LT       = 4'd5,
        FN_GE       = 4'd6,
        FN_LE       = 4'd7,
        FN_EQ       = 4'd8,
        FN_NE       = 4'd9,
        FN_MIN      = 4'd10,
        FN_MAX      = 4'd11,
        FN_INC      = 4'd12,
        FN_DEC      = 4'd13,
        FN_FROM_INT = 4'd14,
        FN_TO_INT   = 4'd15
    } func_t;

endpackage
`default_nettype wire

// ===== hdl/fixed_point_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU (Q24.8 by default), fully pipelined.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields, low bit first     | tuser fields, low bit first
//  --------+-----+---------------------------------+----------------------------
//  s_axis  | in  | operand_a[W-1:0], operand_b[W-1:0] | func[3:0]
//  m_axis  | out | result_word[W-1:0]              | compare_true, overflow,
//          |     |                                 | div_by_zero
//
//  The path length is set by the divider, which resolves one quotient bit
//  per stage. Every operation takes the same path length, so results leave
//  in order and one beat can enter every cycle while the output is not
//  stalled. A stall on the output freezes the whole pipeline in place;
//  nothing is dropped or repeated. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
    parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF,
    parameter int WORD_BITS     = fpa_pkg::WORD_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // operand_a, operand_b, zero pad
    input  wire logic [((2*WORD_BITS+7)/8)*8-1:0] s_tdata,
    // func
    input  wire logic [fpa_pkg::FUNC_BITS-1:0] s_tuser,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // result_word, zero pad
    output logic [((WORD_BITS+7)/8)*8-1:0] m_tdata,
    // compare_true, overflow, div_by_zero
    output logic [2:0] m_tuser
);
    import fpa_pkg::*;

    localparam int W      = WORD_BITS;
    localparam int F      = FRACTION_BITS;
    localparam int QW     = W + F;
    localparam int PW     = 2 * W;
    localparam int OUT_W  = ((W + 7) / 8) * 8;
    localparam int RB     = (F > 0) ? F - 1 : 0;

    localparam logic [W-1:0] MAX_MAG = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_MAG = {1'b1, {(W-1){1'b0}}};

    // sideband that rides alongside the divider stages
    typedef struct packed {
        func_t               func;
        logic                neg;
        logic                sa;
        logic                dz;
        logic signed [W-1:0] res;
        logic                cmp;
        logic                ovf;
        logic [PW-1:0]       prod;
    } side_t;

    // pipeline advances whenever the output register can take a beat
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: capture, split into sign and magnitude ----
    logic                s1_valid_reg;
    func_t               s1_func_reg;
    logic signed [W-1:0] s1_a_reg;
    logic signed [W-1:0] s1_b_reg;
    logic [W-1:0]        s1_ma_reg;
    logic [W-1:0]        s1_mb_reg;

    logic signed [W-1:0] in_a;
    logic signed [W-1:0] in_b;
    assign in_a = s_tdata[0 +: W];
    assign in_b = s_tdata[W +: W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_func_reg <= func_t'(s_tuser);
            s1_a_reg    <= in_a;
            s1_b_reg    <= in_b;
            s1_ma_reg   <= in_a[W-1] ? W'(-in_a) : in_a;
            s1_mb_reg   <= in_b[W-1] ? W'(-in_b) : in_b;
        end
    end

    // ---------------- single-cycle operations ----------------------------
    logic signed [W-1:0] simple_res;
    logic                simple_cmp;
    logic                simple_ovf;

    fpa_simple #(
        .FRACTION_BITS (FRACTION_BITS),
        .WORD_BITS     (WORD_BITS)
    ) u_simple (
        .func (s1_func_reg),
        .a    (s1_a_reg),
        .b    (s1_b_reg),
        .res  (simple_res),
        .cmp  (simple_cmp),
        .ovf  (simple_ovf)
    );

    // ---------------- divider --------------------------------------------
    logic [QW-1:0] div_quo;
    logic [W-1:0]  div_rem;
    logic [W-1:0]  div_den;

    fpa_div #(
        .FRACTION_BITS (FRACTION_BITS),
        .WORD_BITS     (WORD_BITS)
    ) u_div (
        .clk     (clk),
        .adv     (adv),
        .num     (s1_ma_reg),
        .den     (s1_mb_reg),
        .quo     (div_quo),
        .rem     (div_rem),
        .den_out (div_den)
    );

    // ---------------- sideband delay line, product taken on entry --------
    side_t side_in;
    side_t side_reg [QW];
    logic  side_valid_reg [QW];

    always_comb
    begin
        side_in.func  = s1_func_reg;
        side_in.neg   = s1_a_reg[W-1] ^ s1_b_reg[W-1];
        side_in.sa    = s1_a_reg[W-1];
        side_in.dz    = (s1_func_reg == FN_DIV) && (s1_mb_reg == '0);
        side_in.res   = simple_res;
        side_in.cmp   = simple_cmp;
        side_in.ovf   = simple_ovf;
        side_in.prod  = PW'(s1_ma_reg) * PW'(s1_mb_reg);
    end

    genvar gk;
    generate
        for (gk = 0; gk < QW; gk++)
        begin : g_side
            logic  src_valid;
            side_t src;
            if (gk == 0)
            begin : g_first
                assign src_valid = s1_valid_reg;
                assign src       = side_in;
            end
            else
            begin : g_rest
                assign src_valid = side_valid_reg[gk-1];
                assign src       = side_reg[gk-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    side_valid_reg[gk] <= 1'b0;
                else if (adv)
                    side_valid_reg[gk] <= src_valid;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    side_reg[gk] <= src;
            end
        end
    endgenerate

    // ---------------- final stage: round, saturate, select ---------------
    side_t               tail;
    logic                tail_valid;
    logic [W-1:0]        limit;
    logic [PW:0]         rnd_add;
    logic [PW:0]         mul_mag;
    logic [QW:0]         div_mag;
    logic                div_up;
    logic [W-1:0]        mag_sel;
    logic                big;
    logic signed [W-1:0] res_next;
    logic                cmp_next;
    logic                ovf_next;
    logic                dz_next;

    assign tail       = side_reg[QW-1];
    assign tail_valid = side_valid_reg[QW-1];

    always_comb
    begin
        limit   = tail.neg ? MIN_MAG : MAX_MAG;
        rnd_add = (F > 0) ? ((PW+1)'(1) << RB) : '0;
        mul_mag = ({1'b0, tail.prod} + rnd_add) >> F;
        div_up  = (div_rem >= W'(div_den - div_rem));
        div_mag = {1'b0, div_quo} + (QW+1)'(div_up);

        res_next = tail.res;
        cmp_next = tail.cmp;
        ovf_next = tail.ovf;
        dz_next  = 1'b0;
        big      = 1'b0;
        mag_sel  = '0;

        unique case (tail.func)
            FN_MUL:
            begin
                big     = (mul_mag > (PW+1)'(limit));
                mag_sel = big ? limit : mul_mag[W-1:0];
                ovf_next = big;
                res_next = tail.neg ? W'(-mag_sel) : mag_sel;
            end
            FN_DIV:
            begin
                if (tail.dz)
                begin
                    dz_next  = 1'b1;
                    ovf_next = 1'b0;
                    res_next = tail.sa ? MIN_MAG : MAX_MAG;
                end
                else
                begin
                    big      = (div_mag > (QW+1)'(limit));
                    mag_sel  = big ? limit : div_mag[W-1:0];
                    ovf_next = big;
                    res_next = tail.neg ? W'(-mag_sel) : mag_sel;
                end
            end
            default: ; // hold the single-cycle result
        endcase
    end

    // ---------------- output register ------------------------------------
    logic                out_valid_reg;
    logic signed [W-1:0] out_res_reg;
    logic                out_cmp_reg;
    logic                out_ovf_reg;
    logic                out_dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= tail_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_res_reg <= res_next;
            out_cmp_reg <= cmp_next;
            out_ovf_reg <= ovf_next;
            out_dz_reg  <= dz_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_res_reg);
    assign m_tuser  = {out_dz_reg, out_ovf_reg, out_cmp_reg};

endmodule
`default_nettype wire

// ===== hdl/fpa_simple.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_simple
// Single-cycle operations: add, subtract, compare, min/max, step, convert.
// ----------------------------------------------------------------------------
module fpa_simple #(
    parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF,
    parameter int WORD_BITS     = fpa_pkg::WORD_BITS_DEF
) (
    input  wire fpa_pkg::func_t         func,
    input  wire logic signed [WORD_BITS-1:0] a,
    input  wire logic signed [WORD_BITS-1:0] b,
    output logic signed [WORD_BITS-1:0] res,
    output logic                        cmp,
    output logic                        ovf
);
    import fpa_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int FW = WORD_BITS + FRACTION_BITS;

    localparam logic signed [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

    logic signed [W:0]    opnd;
    logic signed [W:0]    sum;
    logic                 do_sub;
    logic signed [FW-1:0] scaled;
    logic                 hi_same;

    always_comb
    begin
        do_sub = (func == FN_SUB) || (func == FN_DEC);
        if ((func == FN_INC) || (func == FN_DEC))
            opnd = (W+1)'(1);
        else
            opnd = {b[W-1], b};
        sum = do_sub ? ({a[W-1], a} - opnd) : ({a[W-1], a} + opnd);

        scaled  = FW'(a) <<< FRACTION_BITS;
        hi_same = (scaled[FW-1:W-1] == {(FRACTION_BITS+1){a[W-1]}});

        res = '0;
        cmp = 1'b0;
        ovf = 1'b0;
        unique case (func)
            FN_ADD, FN_SUB, FN_INC, FN_DEC:
            begin
                if (sum[W] != sum[W-1])
                begin
                    ovf = 1'b1;
                    res = sum[W] ? MIN_W : MAX_W;
                end
                else
                    res = sum[W-1:0];
            end
            FN_GT:       cmp = (a > b);
            FN_LT:       cmp = (a < b);
            FN_GE:       cmp = (a >= b);
            FN_LE:       cmp = (a <= b);
            FN_EQ:       cmp = (a == b);
            FN_NE:       cmp = (a != b);
            FN_MIN:      res = (a < b) ? a : b;
            FN_MAX:      res = (a > b) ? a : b;
            FN_FROM_INT:
            begin
                if (!hi_same)
                begin
                    ovf = 1'b1;
                    res = a[W-1] ? MIN_W : MAX_W;
                end
                else
                    res = scaled[W-1:0];
            end
            FN_TO_INT:   res = a >>> FRACTION_BITS;
            default:     res = '0; // multiply and divide are resolved downstream
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/fpa_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider of magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpa_div #(
    parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF,
    parameter int WORD_BITS     = fpa_pkg::WORD_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   adv,
    input  wire logic [WORD_BITS-1:0]                   num,
    input  wire logic [WORD_BITS-1:0]                   den,
    output logic [WORD_BITS+FRACTION_BITS-1:0]          quo,
    output logic [WORD_BITS-1:0]                        rem,
    output logic [WORD_BITS-1:0]                        den_out
);
    localparam int W  = WORD_BITS;
    localparam int QW = WORD_BITS + FRACTION_BITS;

    logic [W-1:0]  r_reg [QW];
    logic [QW-1:0] n_reg [QW];
    logic [W-1:0]  d_reg [QW];

    genvar gi;
    generate
        for (gi = 0; gi < QW; gi++)
        begin : g_stage
            logic [W-1:0]  r_in;
            logic [QW-1:0] n_in;
            logic [W-1:0]  d_in;
            logic [W:0]    trial;
            logic          fits;
            logic [W-1:0]  r_next;
            logic [QW-1:0] n_next;

            if (gi == 0)
            begin : g_first
                assign r_in = '0;
                assign n_in = QW'(num) << FRACTION_BITS;
                assign d_in = den;
            end
            else
            begin : g_rest
                assign r_in = r_reg[gi-1];
                assign n_in = n_reg[gi-1];
                assign d_in = d_reg[gi-1];
            end

            always_comb
            begin
                trial  = {r_in, n_in[QW-1]};
                fits   = (trial >= {1'b0, d_in});
                r_next = fits ? W'(trial - {1'b0, d_in}) : trial[W-1:0];
                n_next = {n_in[QW-2:0], fits};
            end

            // advance every stage together with the rest of the pipeline
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    r_reg[gi] <= r_next;
                    n_reg[gi] <= n_next;
                    d_reg[gi] <= d_in;
                end
            end
        end
    endgenerate

    assign quo     = n_reg[QW-1];
    assign rem     = r_reg[QW-1];
    assign den_out = d_reg[QW-1];

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the fixed-point ALU: directed corner beats, then
// random operations with random gaps on both sides; every result beat is
// compared field by field against an exact Q24.8 prediction.
// ----------------------------------------------------------------------------

// Holds predicted result beats in order and compares arriving ones.
class alu_scoreboard;
    typedef struct packed {
        logic [31:0] word;
        logic        cmp;
        logic        ovf;
        logic        dz;
    } alu_result_t;

    alu_result_t pending[$];
    int          errors = 0;

    localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
    localparam logic [31:0] MAX_NEG = 32'h8000_0000;

    // Saturate a signed wide value to the 32-bit range.
    static function alu_result_t clamp(input logic signed [127:0] v);
        alu_result_t r;
        r = '0;
        if (v > 128'sh7fff_ffff)
        begin
            r.word = MAX_POS;
            r.ovf  = 1'b1;
        end
        else if (v < -128'sh8000_0000)
        begin
            r.word = MAX_NEG;
            r.ovf  = 1'b1;
        end
        else
            r.word = v[31:0];
        return r;
    endfunction

    // Compute the expected result for one operation.
    static function alu_result_t compute(input fpa_pkg::func_t fn,
                                         input logic signed [31:0] a,
                                         input logic signed [31:0] b);
        alu_result_t      r;
        logic signed [127:0] wa, wb;
        logic [127:0]     ma, mb, mag, q, rem;
        logic             neg;
        r  = '0;
        wa = a;
        wb = b;
        ma = (wa < 0) ? -wa : wa;
        mb = (wb < 0) ? -wb : wb;
        neg = (wa < 0) != (wb < 0);
        case (fn)
            fpa_pkg::FN_ADD:      r = clamp(wa + wb);
            fpa_pkg::FN_SUB:      r = clamp(wa - wb);
            fpa_pkg::FN_MUL:
            begin
                mag = (ma * mb + 128'd128) >> 8;
                r = clamp(neg ? -$signed(mag) : $signed(mag));
            end
            fpa_pkg::FN_DIV:
            begin
                if (mb == 0)
                begin
                    r.dz   = 1'b1;
                    r.word = (wa < 0) ? MAX_NEG : MAX_POS;
                end
                else
                begin
                    q   = (ma << 8) / mb;
                    rem = (ma << 8) % mb;
                    // round half away from zero
                    if (rem >= mb - rem)
                        q = q + 1;
                    r = clamp(neg ? -$signed(q) : $signed(q));
                end
            end
            fpa_pkg::FN_GT:       r.cmp = a >  b;
            fpa_pkg::FN_LT:       r.cmp = a <  b;
            fpa_pkg::FN_GE:       r.cmp = a >= b;
            fpa_pkg::FN_LE:       r.cmp = a <= b;
            fpa_pkg::FN_EQ:       r.cmp = a == b;
            fpa_pkg::FN_NE:       r.cmp = a != b;
            fpa_pkg::FN_MIN:      r.word = (a < b) ? a : b;
            fpa_pkg::FN_MAX:      r.word = (a > b) ? a : b;
            fpa_pkg::FN_INC:      r = clamp(wa + 1);
            fpa_pkg::FN_DEC:      r = clamp(wa - 1);
            fpa_pkg::FN_FROM_INT: r = clamp(wa <<< 8);
            default:              r.word = a >>> 8;
        endcase
        return r;
    endfunction

    function void note_operation(input fpa_pkg::func_t fn,
                                 input logic signed [31:0] a,
                                 input logic signed [31:0] b);
        pending.push_back(compute(fn, a, b));
    endfunction

    function void check_result(input logic [31:0] word, input logic [2:0] flags);
        alu_result_t want;
        if (pending.size() == 0)
        begin
            $error("unexpected result beat %h %b", word, flags);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (word !== want.word)
        begin
            $error("result_word expected %h got %h", want.word, word);
            errors++;
        end
        if (flags[0] !== want.cmp)
        begin
            $error("compare_true expected %b got %b", want.cmp, flags[0]);
            errors++;
        end
        if (flags[1] !== want.ovf)
        begin
            $error("overflow expected %b got %b", want.ovf, flags[1]);
            errors++;
        end
        if (flags[2] !== want.dz)
        begin
            $error("div_by_zero expected %b got %b", want.dz, flags[2]);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import fpa_pkg::*;

    localparam int LATENCY = 41;
    localparam int RANDOM_OPS = 800;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // operand_a, operand_b (from bit 0 up)
    logic [63:0] s_tdata = '0;
    // func
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // result_word (from bit 0 up)
    logic [31:0] m_tdata;
    // compare_true, overflow, div_by_zero (from bit 0 up)
    logic [2:0]  m_tuser;

    logic        stim_done = 1'b0;
    alu_scoreboard results = new();

    fixed_point_alu uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Gap length: mostly zero or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one beat and hold it until accepted; the prediction is noted
    // at the accepting edge.
    task automatic send_op(input func_t fn, input logic [31:0] a, input logic [31:0] b);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= fn;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        results.note_operation(fn, a, b);
        @(negedge clk);
    endtask

    // Operand biased toward the corners and toward small magnitudes.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff - $urandom_range(0, 2);
            1: return 32'h8000_0000 + $urandom_range(0, 2);
            2: return $urandom_range(0, 3) - 1;
            3: return $signed($urandom_range(0, 8192)) - 4096;
            4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom();
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off while input keeps coming.
    initial
    begin
        int gap;
        int beats;
        beats = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (beats == 60)
                gap = 300;
            else
                gap = pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            results.check_result(m_tdata, m_tuser);
            beats++;
        end
    end

    initial
    begin
        logic [31:0] corners[6];
        corners = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff,
                    32'h8000_0000, 32'h0000_0100};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Every operation on corner pairs, plus the named special cases.
        for (int f = 0; f < 16; f++)
            send_op(func_t'(f), corners[f % 6], corners[(f + 3) % 6]);
        send_op(FN_DIV, 32'h0000_0500, 32'h0);
        send_op(FN_DIV, 32'hffff_f000, 32'h0);
        send_op(FN_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
        send_op(FN_MUL, 32'h0000_0001, 32'h0000_0080);
        send_op(FN_DIV, 32'h0000_0001, 32'h0000_0200);
        send_op(FN_INC, 32'h7fff_ffff, 32'h0);
        send_op(FN_DEC, 32'h8000_0000, 32'h0);
        send_op(FN_SUB, 32'h0000_0000, 32'h8000_0000);
        send_op(FN_TO_INT, 32'hffff_ff01, 32'h0);

        for (int i = 0; i < RANDOM_OPS; i++)
            send_op(func_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        wait (results.pending.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (results.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
